// ----- hw/rtl/relr_pkg.sv -----
// ----------------------------------------------------------------------------
// relr_pkg: shared types and constants of the relr relocation decoder
// Widths of the packed word, the queue entry format and the bit-index helper.
// ----------------------------------------------------------------------------
package relr_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned BitmapW   = 63;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned SlotShift = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  // byte distance of one slot and of one full bitmap run
  localparam logic [WordW-1:0] SlotBytes = WordW'(8);
  localparam logic [WordW-1:0] RunBytes  = WordW'(BitmapW * 8);

  // one run of patch addresses: start offset plus the slots to visit
  typedef struct packed {
    logic [WordW-1:0]   start;
    logic [BitmapW-1:0] bits;
  } relr_entry_t;

  // front to queue write request
  typedef struct packed {
    logic        valid;
    relr_entry_t entry;
  } relr_push_t;

  // index of the lowest set bit, zero for an empty vector
  function automatic logic [IdxW-1:0] lowest_set_idx(input logic [BitmapW-1:0] bits);
    logic [BitmapW-1:0] iso;
    logic [IdxW-1:0]    idx;
    iso = bits & (~bits + BitmapW'(1));
    idx = '0;
    for (int i = 0; i < BitmapW; i++) begin
      if (iso[i]) begin
        idx = idx | IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hw/rtl/relr_in_if.sv -----
// ----------------------------------------------------------------------------
// relr_in_if: input channel of the relr decoder
// Valid/ready channel carrying one packed relr word and its table-end flag.
// ----------------------------------------------------------------------------
interface relr_in_if import relr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] packed_word;
  logic             table_end;

  modport source (output valid, output packed_word, output table_end, input ready);
  modport sink   (input valid, input packed_word, input table_end, output ready);
endinterface

// ----- hw/rtl/relr_out_if.sv -----
// ----------------------------------------------------------------------------
// relr_out_if: output channel of the relr decoder
// Valid/ready channel carrying one patch address and its end-of-run flag.
// ----------------------------------------------------------------------------
interface relr_out_if import relr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] patch_address;
  logic             last_of_run;

  modport source (output valid, output patch_address, output last_of_run, input ready);
  modport sink   (input valid, input patch_address, input last_of_run, output ready);
endinterface

// ----- hw/rtl/relr_front.sv -----
// ----------------------------------------------------------------------------
// relr_front: word classifier
// Turns each packed word into a run (start offset and slot bitmap), keeps the
// running slot offset and drops empty bitmaps.
// ----------------------------------------------------------------------------
module relr_front import relr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  relr_in_if.sink    in_i,
  input  logic       full_i,
  output relr_push_t push_o
);

  logic [WordW-1:0] next_slot_q, next_slot_d;
  logic             accept;
  relr_entry_t      entry;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & ~full_i;

  // classify: offset entry is a one-slot run at the offset itself
  always_comb begin
    if (!in_i.packed_word[0]) begin
      entry.start = in_i.packed_word;
      entry.bits  = BitmapW'(1);
      next_slot_d = in_i.packed_word + SlotBytes;
    end else begin
      entry.start = next_slot_q;
      entry.bits  = in_i.packed_word[WordW-1:1];
      next_slot_d = next_slot_q + RunBytes;
    end
    if (in_i.table_end) begin
      next_slot_d = '0;
    end
  end

  // only runs with at least one slot go to the queue
  assign push_o.valid = accept & (|entry.bits);
  assign push_o.entry = entry;

  // running slot offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
    end else if (accept) begin
      next_slot_q <= next_slot_d;
    end
  end

endmodule

// ----- hw/rtl/relr_fifo.sv -----
// ----------------------------------------------------------------------------
// relr_fifo: run queue
// Short queue of runs between the classifier and the address generator.
// ----------------------------------------------------------------------------
module relr_fifo import relr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  relr_push_t  push_i,
  input  logic        pop_i,
  output relr_entry_t entry_o,
  output logic        full_o,
  output logic        empty_o
);

  relr_entry_t         mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - FifoCntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ----- hw/rtl/relr_back.sv -----
// ----------------------------------------------------------------------------
// relr_back: address generator
// Takes runs from the queue and emits one patch address per set slot,
// lowest first, through an output register.
// ----------------------------------------------------------------------------
module relr_back import relr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WordW-1:0] load_base_i,
  input  relr_entry_t      entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  relr_out_if.source       out_o
);

  logic                busy_q;
  logic [WordW-1:0]    base_q;
  logic [BitmapW-1:0]  bits_q, bits_d;
  logic                out_valid_q;
  logic [WordW-1:0]    addr_q, addr_d;
  logic                last_q;
  logic                load, emit;
  logic [IdxW-1:0]     idx;

  assign load  = ~busy_q & ~empty_i;
  assign emit  = busy_q & (~out_valid_q | out_o.ready);
  assign pop_o = load;

  // next slot and its address
  assign idx    = lowest_set_idx(bits_q);
  assign bits_d = bits_q & (bits_q - BitmapW'(1));
  assign addr_d = base_q + {{(WordW-IdxW-SlotShift){1'b0}}, idx, {SlotShift{1'b0}}};

  // run control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit) begin
        busy_q <= |bits_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // run payload and output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      base_q <= load_base_i + entry_i.start;
      bits_q <= entry_i.bits;
    end else if (emit) begin
      bits_q <= bits_d;
    end
    if (emit) begin
      addr_q <= addr_d;
      last_q <= ~(|bits_d);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.patch_address = addr_q;
  assign out_o.last_of_run   = last_q;

endmodule

// ----- hw/rtl/relr_relocation_decoder.sv -----
// ----------------------------------------------------------------------------
// relr_relocation_decoder: relr relative-relocation decoder
// Expands packed relr words into absolute patch addresses.
// ----------------------------------------------------------------------------
// An offset word takes a run load in the address generator, then one address;
// a bitmap word with k set slots a run load, then k addresses, one per cycle
// while the output is ready, and an empty bitmap none. The address generator
// sets the rate; the classifier takes a word every cycle while the four-entry
// run queue has room, so words are accepted while earlier runs are still being
// expanded. load_base is sampled when a run leaves the queue. The user must
// write it only while the block is idle; the block does not enforce this.
module relr_relocation_decoder import relr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_base_we_i,
  input  logic [WordW-1:0] load_base_wdata_i,
  relr_in_if.sink          in_i,
  relr_out_if.source       out_o
);

  logic [WordW-1:0] load_base_q;
  relr_push_t       push;
  relr_entry_t      head;
  logic             full, empty, pop;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_base_q <= '0;
    end else if (load_base_we_i) begin
      load_base_q <= load_base_wdata_i;
    end
  end

  // classifier
  relr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  // run queue
  relr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .entry_o (head),
    .full_o  (full),
    .empty_o (empty)
  );

  // address generator
  relr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_base_i (load_base_q),
    .entry_i     (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ----- tb/relr_relocation_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// relr_relocation_decoder_tb: self-checking bench of the relr decoder
// Streams offset and bitmap words through the input channel, expands each
// accepted word into its patch addresses in a local decoder, and compares
// every address transaction on the output channel in order. Both channels
// idle in random bursts; one long output hold-off fills the run queue.
// ----------------------------------------------------------------------------
module relr_relocation_decoder_tb;
  import relr_pkg::*;

  localparam int unsigned DrainCycles = 100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxPrinted  = 40;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             tend;
  } relr_word_t;

  typedef struct packed {
    logic [WordW-1:0] addr;
    logic             last;
  } patch_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             load_base_we;
  logic [WordW-1:0] load_base_wdata;

  relr_in_if  in_if ();
  relr_out_if out_if ();

  relr_relocation_decoder u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_base_we_i    (load_base_we),
    .load_base_wdata_i (load_base_wdata),
    .in_i              (in_if.sink),
    .out_o             (out_if.source)
  );

  // local copy of the decoder state
  logic [WordW-1:0] base_mdl = '0;
  logic [WordW-1:0] slot_ofs = '0;

  relr_word_t word_q[$];
  patch_t     patch_q[$];

  int unsigned err_cnt      = 0;
  int unsigned words_queued = 0;
  int unsigned words_in     = 0;
  int unsigned patches_seen = 0;
  int unsigned base_writes  = 0;

  logic       calm = 1'b0;
  logic       hold_on = 1'b0;
  int         src_gap = 0;
  int         snk_gap = 0;
  event       hold_go;

  always #1 clk_i = ~clk_i;

  // known values on every block input before the first edge
  initial begin
    in_if.valid       = 1'b0;
    in_if.packed_word = '0;
    in_if.table_end   = 1'b0;
    out_if.ready      = 1'b0;
    load_base_we      = 1'b0;
    load_base_wdata   = '0;
  end

  task automatic report_mismatch(input string what);
    if (err_cnt < MaxPrinted) begin
      $display("MISMATCH: %s", what);
    end
    err_cnt++;
  endtask

  // expand one relr word into the patch addresses it stands for
  task automatic expand_word(input logic [WordW-1:0] word, input logic tend);
    logic [BitmapW-1:0] bits;
    patch_t             p;
    if (!word[0]) begin
      p.addr = base_mdl + word;
      p.last = 1'b1;
      patch_q.push_back(p);
      slot_ofs = word + SlotBytes;
    end else begin
      bits = word[WordW-1:1];
      for (int n = 0; n < BitmapW; n++) begin
        if (bits[n]) begin
          p.addr = base_mdl + slot_ofs + WordW'(n) * SlotBytes;
          p.last = (n == BitmapW - 1) || ((bits >> (n + 1)) == '0);
          patch_q.push_back(p);
        end
      end
      slot_ofs = slot_ofs + RunBytes;
    end
    if (tend) begin
      slot_ofs = '0;
    end
  endtask

  function automatic logic [WordW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [WordW-1:0] rand_bitmap();
    logic [WordW-1:0] w;
    case ($urandom_range(0, 4))
      0: w = rand64();
      1: w = rand64() & rand64() & rand64();
      2: w = WordW'(1) << $urandom_range(1, 63);
      3: w = rand64() | rand64();
      default: w = ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
    return w | WordW'(1);
  endfunction

  function automatic logic [WordW-1:0] rand_offset();
    logic [WordW-1:0] w;
    case ($urandom_range(0, 2))
      0: w = rand64();
      1: w = WordW'($urandom_range(0, 65535));
      default: w = ~WordW'($urandom_range(0, 4095));
    endcase
    return w & ~WordW'(1);
  endfunction

  task automatic push_word(input logic [WordW-1:0] word, input logic tend);
    relr_word_t it;
    it.word = word;
    it.tend = tend;
    word_q.push_back(it);
    words_queued++;
  endtask

  // mostly well-formed tables (offset then bitmaps, end flag on the last),
  // sometimes a table that opens with a bitmap, plus some raw noise
  task automatic queue_tables(input int unsigned count);
    int unsigned target;
    int unsigned nbm;
    target = words_queued + count;
    while (words_queued < target) begin
      if ($urandom_range(0, 4) == 0) begin
        push_word(rand64(), $urandom_range(0, 7) == 0);
      end else begin
        nbm = $urandom_range(0, 4);
        if ($urandom_range(0, 5) != 0) begin
          push_word(rand_offset(), nbm == 0);
        end
        for (int i = 0; i < nbm; i++) begin
          push_word(rand_bitmap(), i == nbm - 1);
        end
      end
    end
  endtask

  task automatic set_load_base(input logic [WordW-1:0] value);
    @(posedge clk_i);
    load_base_we    <= 1'b1;
    load_base_wdata <= value;
    @(posedge clk_i);
    load_base_we    <= 1'b0;
    base_mdl = value;
    base_writes++;
  endtask

  // all words taken, all addresses seen, then a drain wait
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (word_q.size() != 0 || in_if.valid || patch_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // input driver: next word from the pending queue, random idle bursts
  always @(posedge clk_i) begin : drive_words
    relr_word_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (src_gap != 0) begin
        src_gap     <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (!calm && word_q.size() != 0 && $urandom_range(0, 9) == 0) begin
        src_gap     <= $urandom_range(0, 18);
        in_if.valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        it                 = word_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.packed_word <= it.word;
        in_if.table_end   <= it.tend;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // input monitor: each accepted transaction feeds the local decoder
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      expand_word(in_if.packed_word, in_if.table_end);
      words_in++;
    end
  end

  // long output hold-off, counted here while the sender keeps offering
  always begin
    @(hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // output ready: random stall bursts, none in the calm tail
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_on) begin
      out_if.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap      <= snk_gap - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      snk_gap      <= $urandom_range(0, 18);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // output monitor: compare each address transaction with the oldest one due
  always @(posedge clk_i) begin : check_patches
    patch_t p;
    if (rst_ni && out_if.valid && out_if.ready) begin
      patches_seen++;
      if (patch_q.size() == 0) begin
        report_mismatch($sformatf("unexpected address %h last %b",
                                  out_if.patch_address, out_if.last_of_run));
      end else begin
        p = patch_q.pop_front();
        if (out_if.patch_address !== p.addr) begin
          report_mismatch($sformatf("patch_address %h, want %h",
                                    out_if.patch_address, p.addr));
        end
        if (out_if.last_of_run !== p.last) begin
          report_mismatch($sformatf("last_of_run %b, want %b at address %h",
                                    out_if.last_of_run, p.last, p.addr));
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words, base zero; the first one is a bitmap before any offset
    set_load_base('0);
    push_word(64'h0000_0000_0000_000B, 1'b0);
    push_word(64'h0000_0000_0000_0001, 1'b0);  // empty bitmap
    push_word(64'h0000_0000_0000_0000, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // every slot set
    push_word(64'hFFFF_FFFF_FFFF_FFF8, 1'b0);  // slot pointer wraps to zero
    push_word(64'h8000_0000_0000_0001, 1'b0);  // top slot only
    push_word(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);  // largest offset, table end
    push_word(64'h0000_0000_0000_0003, 1'b0);  // bitmap right after table end
    push_word(64'hAAAA_AAAA_AAAA_AAAB, 1'b0);
    push_word(64'h5555_5555_5555_5555, 1'b1);  // bitmap carries table end
    push_word(64'h0000_0000_0000_0001, 1'b1);  // empty bitmap with table end
    push_word(64'h0000_0000_0000_0008, 1'b0);
    push_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FE00, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // run reaches the top address
    push_word(64'h1234_5678_9ABC_DEF0, 1'b1);
    push_word(64'h0000_0000_0000_0000, 1'b1);
    wait_idle();

    // base all ones: sums wrap; the hold-off backs up the run queue
    set_load_base('1);
    push_word(64'h0000_0000_0000_0000, 1'b0);
    push_word(64'h0000_0000_0000_0002, 1'b0);
    push_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    queue_tables(100);
    -> hold_go;
    wait_idle();

    set_load_base(rand64());
    queue_tables(90);
    wait_idle();
    set_load_base(rand64());
    queue_tables(90);
    wait_idle();

    // last part without idling on either side
    set_load_base(64'h8000_0000_0000_0000);
    calm <= 1'b1;
    queue_tables(130);
    wait_idle();

    $display("covered %0d relr words under %0d load base settings", words_in, base_writes);
    $display("compared %0d patch address transactions", patches_seen);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/relr_pkg.sv
hw/rtl/relr_in_if.sv
hw/rtl/relr_out_if.sv
hw/rtl/relr_front.sv
hw/rtl/relr_fifo.sv
hw/rtl/relr_back.sv
hw/rtl/relr_relocation_decoder.sv
tb/relr_relocation_decoder_tb.sv
